[hdl/median_of_block_top_defines.svh]
// ----------------------------------------------------------------------------
// median_of_block_top_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OF_BLOCK_TOP_DEFINES_SVH
`define MEDIAN_OF_BLOCK_TOP_DEFINES_SVH

// property must hold at every sampled edge outside reset
`define MOB_ASSERT_HOLD(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("median_of_block: invariant violated");

// consequent must hold in the cycle after the antecedent
`define MOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("median_of_block: sequence violated");

`endif

[hdl/mob_pkg.sv]
// ----------------------------------------------------------------------------
// mob_pkg
// types and constants of the block median unit
// ----------------------------------------------------------------------------
`default_nettype none

package mob_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int COUNT_OUT_W = 7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_SRD,
		S_SCMP,
		S_INS,
		S_MRD0,
		S_MRD1,
		S_MOUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_prev;
		logic shift_wr;
		logic ins_wr;
		logic med_first;
		logic med_second;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_one;
		logic greater;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

[hdl/median_of_block_top.sv]
// ----------------------------------------------------------------------------
// median_of_block_top
// median of a block of signed q16.16 samples kept in a sorted memory
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one word: sample and last.
//   last marks the final sample of a block. up to 64 samples are kept in
//   ascending order; further samples of the block are dropped and flag
//   overflow in the result.
//   output channel out_valid/out_ready carries one word per block:
//   median_value (middle element, or floor average of the two middle
//   elements for an even count), overflow and sample_count.
// timing:
//   insertion walks the single-port memory downward, a read and then a
//   compare and write per entry moved. a sample moves each stored entry
//   greater than it, with no final read and compare when it is below every
//   stored entry or the store is empty; a dropped sample is not written.
//   a last sample adds the two middle reads before the result register
//   loads.
// reset clears count, drop flag, controller and output valid; memory
// contents need no clearing. a stalled receiver holds the result; the block
// keeps taking samples and waits only when a new result finds the output
// register still full.
// ----------------------------------------------------------------------------
`default_nettype none

module median_of_block_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [mob_pkg::DATA_W-1:0] sample,
	input  wire logic                              last,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [mob_pkg::DATA_W-1:0]      median_value,
	output logic                                   overflow,
	output logic [mob_pkg::COUNT_OUT_W-1:0]        sample_count
);

	mob_pkg::ctrl_cmd_t  cmd;
	mob_pkg::dp_status_t status;

	mob_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mob_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.last         (last),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.median_value (median_value),
		.overflow     (overflow),
		.sample_count (sample_count)
	);

endmodule

`default_nettype wire

[hdl/mob_ctrl.sv]
// ----------------------------------------------------------------------------
// mob_ctrl
// sequencer for insertion into the sorted store and the median read-out
// ----------------------------------------------------------------------------
`default_nettype none

module mob_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  mob_pkg::dp_status_t     status,
	output mob_pkg::ctrl_cmd_t      cmd
);

	mob_pkg::state_t state_q;
	mob_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mob_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mob_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = mob_pkg::S_DISP;
				end
			end
			mob_pkg::S_DISP: begin
				// full store drops the word, an empty one takes it at slot zero
				if (status.full) begin
					state_d = status.last ? mob_pkg::S_MRD0 : mob_pkg::S_IDLE;
				end else if (status.empty) begin
					state_d = mob_pkg::S_INS;
				end else begin
					state_d = mob_pkg::S_SRD;
				end
			end
			mob_pkg::S_SRD: begin
				cmd.rd_prev = 1'b1;
				state_d     = mob_pkg::S_SCMP;
			end
			mob_pkg::S_SCMP: begin
				if (status.greater) begin
					cmd.shift_wr = 1'b1;
					state_d      = status.pos_one ? mob_pkg::S_INS : mob_pkg::S_SRD;
				end else begin
					state_d = mob_pkg::S_INS;
				end
			end
			mob_pkg::S_INS: begin
				cmd.ins_wr = 1'b1;
				state_d    = status.last ? mob_pkg::S_MRD0 : mob_pkg::S_IDLE;
			end
			mob_pkg::S_MRD0: begin
				cmd.med_first = 1'b1;
				state_d       = mob_pkg::S_MRD1;
			end
			mob_pkg::S_MRD1: begin
				cmd.med_second = 1'b1;
				state_d        = mob_pkg::S_MOUT;
			end
			mob_pkg::S_MOUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mob_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mob_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hdl/mob_dp.sv]
// ----------------------------------------------------------------------------
// mob_dp
// sorted sample memory, insertion pointer, fill count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mob_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic signed [mob_pkg::DATA_W-1:0]     sample,
	input  wire logic                                  last,
	input  mob_pkg::ctrl_cmd_t                         cmd,
	output mob_pkg::dp_status_t                        status,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [mob_pkg::DATA_W-1:0]          median_value,
	output logic                                       overflow,
	output logic [mob_pkg::COUNT_OUT_W-1:0]            sample_count
);

	logic [mob_pkg::DATA_W-1:0] mem [mob_pkg::MAX_SAMPLES];

	logic signed [mob_pkg::DATA_W-1:0] sample_q;
	logic                              last_q;
	logic [mob_pkg::CNT_W-1:0]         fill_q;
	logic [mob_pkg::CNT_W-1:0]         pos_q;
	logic                              drop_q;
	logic signed [mob_pkg::DATA_W-1:0] rdata_q;
	logic signed [mob_pkg::DATA_W-1:0] a_q;
	logic                              out_valid_q;
	logic signed [mob_pkg::DATA_W-1:0] median_q;
	logic                              overflow_q;
	logic [mob_pkg::COUNT_OUT_W-1:0]   count_q;

	logic [mob_pkg::CNT_W-1:0]  pos_m1;
	logic [mob_pkg::CNT_W-1:0]  half;
	logic [mob_pkg::CNT_W-1:0]  half_m1;
	logic                       rd_en;
	logic [mob_pkg::ADDR_W-1:0] rd_addr;
	logic                       wr_en;
	logic [mob_pkg::ADDR_W-1:0] wr_addr;
	logic [mob_pkg::DATA_W-1:0] wr_data;
	logic signed [mob_pkg::DATA_W:0] pair_sum;
	logic signed [mob_pkg::DATA_W-1:0] median_d;

	assign pos_m1  = pos_q - mob_pkg::CNT_W'(1);
	assign half    = fill_q >> 1;
	assign half_m1 = half - mob_pkg::CNT_W'(1);

	always_comb begin
		rd_en   = cmd.rd_prev | cmd.med_first | cmd.med_second;
		rd_addr = half[mob_pkg::ADDR_W-1:0];
		if (cmd.rd_prev) begin
			rd_addr = pos_m1[mob_pkg::ADDR_W-1:0];
		end else if (cmd.med_first && !fill_q[0]) begin
			// even count starts with the lower middle element
			rd_addr = half_m1[mob_pkg::ADDR_W-1:0];
		end
	end

	assign wr_en   = cmd.shift_wr | cmd.ins_wr;
	assign wr_addr = pos_q[mob_pkg::ADDR_W-1:0];
	assign wr_data = cmd.shift_wr ? rdata_q : sample_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// floor average of the two middle elements, or the middle one for an odd count
	assign pair_sum = {a_q[mob_pkg::DATA_W-1], a_q} + {rdata_q[mob_pkg::DATA_W-1], rdata_q};
	assign median_d = fill_q[0] ? a_q : pair_sum[mob_pkg::DATA_W:1];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.med_second) begin
			a_q <= rdata_q;
		end
		if (cmd.out_load) begin
			median_q   <= median_d;
			overflow_q <= drop_q;
			count_q    <= mob_pkg::COUNT_OUT_W'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			fill_q      <= '0;
			pos_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				last_q <= last;
				pos_q  <= fill_q;
				if (fill_q == mob_pkg::CNT_W'(mob_pkg::MAX_SAMPLES)) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.shift_wr) begin
				pos_q <= pos_m1;
			end
			if (cmd.ins_wr) begin
				fill_q <= fill_q + mob_pkg::CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				fill_q      <= '0;
				drop_q      <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.full     = (fill_q == mob_pkg::CNT_W'(mob_pkg::MAX_SAMPLES));
	assign status.empty    = (fill_q == '0);
	assign status.pos_one  = (pos_q == mob_pkg::CNT_W'(1));
	assign status.greater  = (rdata_q > sample_q);
	assign status.last     = last_q;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign median_value = median_q;
	assign overflow     = overflow_q;
	assign sample_count = count_q;

endmodule

`default_nettype wire

[hdl/mob_checker.sv]
// ----------------------------------------------------------------------------
// mob_checker
// port-level checks of the block median unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_of_block_top_defines.svh"

module mob_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [mob_pkg::DATA_W-1:0] median_value,
	input wire logic                              overflow,
	input wire logic [mob_pkg::COUNT_OUT_W-1:0]   sample_count
);

	// stalled result word holds
	`MOB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(median_value) && $stable(overflow) && $stable(sample_count))

	// a result always covers at least one stored sample and never more than the store
	`MOB_ASSERT_HOLD(a_count_range, clk, arst_n, !out_valid || (sample_count != '0 && sample_count <= mob_pkg::COUNT_OUT_W'(mob_pkg::MAX_SAMPLES)))

	// one sample at a time: ready drops right after an accept
	`MOB_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

	// a fresh result never appears in the cycle right after a sample is taken
	`MOB_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind median_of_block_top mob_checker u_mob_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.median_value (median_value),
	.overflow     (overflow),
	.sample_count (sample_count)
);

`default_nettype wire

[dv/tb_median_of_block_top.sv]
// ----------------------------------------------------------------------------
// tb_median_of_block_top
// checks the block median unit against a sorted-block predictor
// ----------------------------------------------------------------------------
// samples are pushed one per input word with random gaps. On every accepted
// word the predictor inserts the value, unless full, into its sorted copy.
// On a last word it works out median, drop flag and count, and queues them.
// Each output word is compared field by field with the oldest queued result.
// Tests: directed corner blocks, full and overfull blocks, a long receiver
// hold-off that backs the block up, and random blocks of mostly small size.
// ----------------------------------------------------------------------------
module tb_median_of_block_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_SAMPLES = 1850;
	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 200;

	typedef logic signed [mob_pkg::DATA_W-1:0] q16_t;

	localparam q16_t Q_MAX = {1'b0, {(mob_pkg::DATA_W-1){1'b1}}};
	localparam q16_t Q_MIN = {1'b1, {(mob_pkg::DATA_W-1){1'b0}}};

	typedef struct {
		q16_t                            median;
		logic                            dropped;
		logic [mob_pkg::COUNT_OUT_W-1:0] count;
	} median_result_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	q16_t                            sample    = '0;
	logic                            last      = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	q16_t                            median_value;
	logic                            overflow;
	logic [mob_pkg::COUNT_OUT_W-1:0] sample_count;

	// predictor state
	q16_t           block_sorted[$];
	logic           block_dropped = 1'b0;
	median_result_t pending_medians[$];

	int   err_count    = 0;
	int   sent_samples = 0;
	int   result_idx   = 0;
	int   cycle_count  = 0;
	int   hold_left    = 0;
	logic gaps_on      = 1'b1;

	median_of_block_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.median_value (median_value),
		.overflow     (overflow),
		.sample_count (sample_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// insert into the sorted block copy; on last produce the median word
	function automatic void absorb_sample(input q16_t value, input logic is_last);
		median_result_t                  res;
		int                              pos;
		int                              n;
		logic signed [mob_pkg::DATA_W:0] pair_sum;
		if (block_sorted.size() < mob_pkg::MAX_SAMPLES) begin
			pos = block_sorted.size();
			while (pos > 0 && block_sorted[pos-1] > value)
				pos--;
			block_sorted.insert(pos, value);
		end else begin
			block_dropped = 1'b1;
		end
		if (is_last) begin
			n = block_sorted.size();
			if (n % 2 == 1) begin
				res.median = block_sorted[n/2];
			end else begin
				// 33-bit sum, dropping the low bit floors toward minus infinity
				pair_sum = {block_sorted[n/2-1][mob_pkg::DATA_W-1], block_sorted[n/2-1]}
					+ {block_sorted[n/2][mob_pkg::DATA_W-1], block_sorted[n/2]};
				res.median = pair_sum[mob_pkg::DATA_W:1];
			end
			res.dropped = block_dropped;
			res.count   = mob_pkg::COUNT_OUT_W'(n);
			pending_medians.push_back(res);
			block_sorted.delete();
			block_dropped = 1'b0;
		end
	endfunction

	task automatic check_median_word();
		median_result_t exp_res;
		if (pending_medians.size() == 0) begin
			report_mismatch($sformatf("unexpected word: median %0d overflow %0b count %0d",
				median_value, overflow, sample_count));
			return;
		end
		exp_res = pending_medians.pop_front();
		if (median_value !== exp_res.median)
			report_mismatch($sformatf("result %0d median_value %0d, expected %0d",
				result_idx, median_value, exp_res.median));
		if (overflow !== exp_res.dropped)
			report_mismatch($sformatf("result %0d overflow %0b, expected %0b",
				result_idx, overflow, exp_res.dropped));
		if (sample_count !== exp_res.count)
			report_mismatch($sformatf("result %0d sample_count %0d, expected %0d",
				result_idx, sample_count, exp_res.count));
		result_idx++;
	endtask

	// receiver: checks accepted words, random stalls, and a counted hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_median_word();
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else begin
				out_ready <= !(gaps_on && $urandom_range(99) < 32);
			end
		end
	end

	task automatic send_sample(input q16_t value, input logic is_last);
		while (gaps_on && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		last     <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		absorb_sample(value, is_last);
		sent_samples++;
	endtask

	function automatic q16_t pick_sample();
		case ($urandom_range(9))
			0: return Q_MIN;
			1: return Q_MAX;
			2, 3: return q16_t'(int'($urandom_range(64)) - 32);
			// a few whole values, so equal samples are common
			4: return q16_t'((int'($urandom_range(3)) - 1) <<< 16);
			default: return q16_t'($urandom);
		endcase
	endfunction

	// mostly short blocks, a few full or overfull ones
	function automatic int pick_block_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return $urandom_range(1, 12);
		else if (roll < 90)
			return $urandom_range(13, 40);
		else if (roll < 98)
			return $urandom_range(41, mob_pkg::MAX_SAMPLES);
		else
			return $urandom_range(mob_pkg::MAX_SAMPLES + 1, mob_pkg::MAX_SAMPLES + 16);
	endfunction

	task automatic send_block(input q16_t vals[$]);
		foreach (vals[i])
			send_sample(vals[i], i == vals.size() - 1);
	endtask

	// input goes idle while waiting, so the last word is not taken again
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_medians.size() > 0)
			@(posedge clk);
	endtask

	task automatic test_corner_blocks();
		gaps_on <= 1'b1;
		send_block('{Q_MAX});
		send_block('{Q_MIN});
		// extremes averaged: -0.5 lsb floors to -1
		send_block('{Q_MAX, Q_MIN});
		send_block('{Q_MIN, Q_MIN});
		send_block('{Q_MAX, Q_MAX});
		send_block('{q16_t'(-3), q16_t'(0)});
		send_block('{q16_t'(5), q16_t'(1), q16_t'(3)});
		send_block('{q16_t'(7), q16_t'(7), q16_t'(-1), q16_t'(7)});
		send_block('{q16_t'(32'h0001_0000), q16_t'(32'hFFFF_0000), q16_t'(0),
			q16_t'(1), q16_t'(-1)});
		send_block('{q16_t'(4), q16_t'(3), q16_t'(2), q16_t'(1)});
	endtask

	task automatic test_full_store();
		// exactly full, in descending order so every insert walks the whole store
		for (int i = 0; i < mob_pkg::MAX_SAMPLES; i++)
			send_sample(q16_t'(mob_pkg::MAX_SAMPLES - i) <<< 10,
				i == mob_pkg::MAX_SAMPLES - 1);
		// one over: the last word itself is dropped
		for (int i = 0; i <= mob_pkg::MAX_SAMPLES; i++)
			send_sample(pick_sample(), i == mob_pkg::MAX_SAMPLES);
		for (int i = 0; i < mob_pkg::MAX_SAMPLES + 36; i++)
			send_sample(q16_t'($urandom), i == mob_pkg::MAX_SAMPLES + 35);
		// a short block right after, to see the drop flag cleared
		send_block('{q16_t'(9), q16_t'(-9)});
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		gaps_on   <= 1'b0;
		hold_left <= HOLD_CYCLES;
		@(posedge clk);
		// more results than the output register holds, so the input stalls
		for (int b = 0; b < 8; b++)
			for (int i = 0; i < 4; i++)
				send_sample(pick_sample(), i == 3);
	endtask

	task automatic test_random_blocks();
		int n;
		while (sent_samples < TARGET_SAMPLES) begin
			// a long stretch with no gaps on either side
			gaps_on <= !(sent_samples >= 700 && sent_samples < 1000);
			n = pick_block_len();
			for (int i = 0; i < n; i++)
				send_sample(pick_sample(), i == n - 1);
		end
		gaps_on <= 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_blocks();
		test_full_store();
		test_output_backpressure();
		test_random_blocks();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_medians.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
